FILE: src/lcfp_pkg.sv
package lcfp_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned RegIdxW = 2;

    localparam logic [RegIdxW-1:0] RegWinLeft   = 2'd0;
    localparam logic [RegIdxW-1:0] RegWinTop    = 2'd1;
    localparam logic [RegIdxW-1:0] RegWinRight  = 2'd2;
    localparam logic [RegIdxW-1:0] RegWinBottom = 2'd3;

    localparam logic signed [CoordW-1:0] ResetWinLeft   = 16'sd0;
    localparam logic signed [CoordW-1:0] ResetWinTop    = 16'sd0;
    localparam logic signed [CoordW-1:0] ResetWinRight  = 16'sd319;
    localparam logic signed [CoordW-1:0] ResetWinBottom = 16'sd199;

    // outcode bits
    localparam int unsigned OcLeft   = 0;
    localparam int unsigned OcRight  = 1;
    localparam int unsigned OcTop    = 2;
    localparam int unsigned OcBottom = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_LERP,
        S_UPDATE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture a new request
        logic setup;    // choose edge and start division
        logic div_step; // one quotient bit
        logic lerp;     // form interpolation product
        logic update;   // move the endpoint, refresh outcode
        logic finish;   // drive the result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reject;
        logic accept;
        logic div_last;
        logic zero_den;
    } t_status;

endpackage

FILE: src/line_clipper_fixed_point.sv
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------
// request   | i_start_x, i_start_y, i_end_x, i_end_y         | i_start && !o_busy
// result    | o_visible, o_clip_start/end_x/y                | o_done, one cycle
// config    | i_cfg_idx, i_cfg_data                          | i_cfg_we
// Each clip pass runs the bit-serial divider, one quotient bit per cycle.
// Reset (synchronous, active low) returns to idle and loads the default window.
// The result cannot be stalled; o_busy stays high through the result strobe.
module line_clipper_fixed_point
    import lcfp_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = 8,
    parameter int unsigned MAX_PASSES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [RegIdxW-1:0]        i_cfg_idx,
    input  logic [CoordW-1:0]         i_cfg_data,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic signed [CoordW-1:0]  i_start_x,
    input  logic signed [CoordW-1:0]  i_start_y,
    input  logic signed [CoordW-1:0]  i_end_x,
    input  logic signed [CoordW-1:0]  i_end_y,
    output logic                      o_done,
    output logic                      o_visible,
    output logic signed [CoordW-1:0]  o_clip_start_x,
    output logic signed [CoordW-1:0]  o_clip_start_y,
    output logic signed [CoordW-1:0]  o_clip_end_x,
    output logic signed [CoordW-1:0]  o_clip_end_y
);

    logic signed [CoordW-1:0] r_win_left, r_win_top, r_win_right, r_win_bottom;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= ResetWinLeft;
            r_win_top    <= ResetWinTop;
            r_win_right  <= ResetWinRight;
            r_win_bottom <= ResetWinBottom;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegWinLeft:   r_win_left   <= i_cfg_data;
                RegWinTop:    r_win_top    <= i_cfg_data;
                RegWinRight:  r_win_right  <= i_cfg_data;
                RegWinBottom: r_win_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcfp_ctrl #(
        .MAX_PASSES (MAX_PASSES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    lcfp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_win_left     (r_win_left),
        .i_win_top      (r_win_top),
        .i_win_right    (r_win_right),
        .i_win_bottom   (r_win_bottom),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_visible      (o_visible),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y)
    );

endmodule

FILE: src/lcfp_datapath.sv
module lcfp_datapath
    import lcfp_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic signed [CoordW-1:0] i_win_left,
    input  logic signed [CoordW-1:0] i_win_top,
    input  logic signed [CoordW-1:0] i_win_right,
    input  logic signed [CoordW-1:0] i_win_bottom,
    input  logic signed [CoordW-1:0] i_start_x,
    input  logic signed [CoordW-1:0] i_start_y,
    input  logic signed [CoordW-1:0] i_end_x,
    input  logic signed [CoordW-1:0] i_end_y,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic                     o_visible,
    output logic signed [CoordW-1:0] o_clip_start_x,
    output logic signed [CoordW-1:0] o_clip_start_y,
    output logic signed [CoordW-1:0] o_clip_end_x,
    output logic signed [CoordW-1:0] o_clip_end_y
);

    // fixed-point coordinates: endpoints stay within the hull of inputs and window
    localparam int unsigned PW = CoordW + FRAC_BITS + 1;
    // numerator |edge - p0| and denominator |p1 - p0|
    localparam int unsigned DW = PW + 1;
    // dividend = |num| << FRAC_BITS
    localparam int unsigned NW = DW + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);
    localparam int unsigned TW = FRAC_BITS + 2;
    localparam int unsigned MW = DW + TW;
    localparam logic [TW-1:0] TOne = TW'(1) << FRAC_BITS;

    logic signed [CoordW-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [PW-1:0]     r_ax, r_ay, r_bx, r_by;
    logic [3:0]               r_c0, r_c1;
    logic                     r_side;   // 0: move start, 1: move end
    logic                     r_is_y;   // edge is top or bottom
    logic signed [PW-1:0]     r_edge;
    logic signed [DW-1:0]     r_span;   // b - a of the other axis
    logic signed [PW-1:0]     r_base;   // a of the other axis
    logic [NW-1:0]            r_quo;
    logic [DW:0]              r_rem;
    logic [DW-1:0]            r_den;
    logic                     r_neg;
    logic                     r_zero;
    logic [CW-1:0]            r_cnt;
    logic signed [MW-1:0]     r_prod;
    logic                     r_vis;
    logic signed [CoordW-1:0] r_osx, r_osy, r_oex, r_oey;

    function automatic logic [3:0] region(
        input logic signed [PW-FRAC_BITS-1:0] x,
        input logic signed [PW-FRAC_BITS-1:0] y,
        input logic signed [CoordW-1:0]       wl,
        input logic signed [CoordW-1:0]       wt,
        input logic signed [CoordW-1:0]       wr,
        input logic signed [CoordW-1:0]       wb
    );
        logic [3:0] c;
        c = '0;
        if (x < wl) c[OcLeft] = 1'b1;
        else if (x > wr) c[OcRight] = 1'b1;
        if (y < wt) c[OcTop] = 1'b1;
        else if (y > wb) c[OcBottom] = 1'b1;
        return c;
    endfunction

    logic [3:0]               co;
    logic signed [PW-1:0]     p0, p1, q0, q1, edge_fx;
    logic signed [DW-1:0]     num, den;
    logic                     use_y;
    logic [DW:0]              rem_sh, rem_sub;
    logic [TW-1:0]            t_val;
    logic signed [PW-1:0]     shifted, new_v;
    logic signed [PW-1:0]     nx, ny;
    logic signed [PW-FRAC_BITS-1:0] fx, fy;
    logic [3:0]               nc;

    always_comb begin
        co = (r_c0 != 4'd0) ? r_c0 : r_c1;
        use_y = co[OcTop] | co[OcBottom];
        if (co[OcTop]) begin
            edge_fx = PW'(i_win_top) <<< FRAC_BITS;
        end else if (co[OcBottom]) begin
            edge_fx = PW'(i_win_bottom) <<< FRAC_BITS;
        end else if (co[OcLeft]) begin
            edge_fx = PW'(i_win_left) <<< FRAC_BITS;
        end else begin
            edge_fx = PW'(i_win_right) <<< FRAC_BITS;
        end
        p0 = use_y ? r_ay : r_ax;
        p1 = use_y ? r_by : r_bx;
        q0 = use_y ? r_ax : r_ay;
        q1 = use_y ? r_bx : r_by;
        num = DW'(edge_fx) - DW'(p0);
        den = DW'(p1) - DW'(p0);

        rem_sh  = {r_rem[DW-1:0], r_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};

        // saturate ratio to [0, one]
        if (r_zero || r_neg) begin
            t_val = '0;
        end else if (r_quo > NW'(TOne)) begin
            t_val = TOne;
        end else begin
            t_val = r_quo[TW-1:0];
        end

        shifted = PW'(r_prod >>> FRAC_BITS);
        new_v   = r_base + shifted;
        nx = r_is_y ? new_v : r_edge;
        ny = r_is_y ? r_edge : new_v;
        fx = nx[PW-1:FRAC_BITS];
        fy = ny[PW-1:FRAC_BITS];
        nc = region(fx, fy, i_win_left, i_win_top, i_win_right, i_win_bottom);
    end

    logic signed [PW-FRAC_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
    assign in_sx = (PW-FRAC_BITS)'(i_start_x);
    assign in_sy = (PW-FRAC_BITS)'(i_start_y);
    assign in_ex = (PW-FRAC_BITS)'(i_end_x);
    assign in_ey = (PW-FRAC_BITS)'(i_end_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= i_start_x;
            r_sy <= i_start_y;
            r_ex <= i_end_x;
            r_ey <= i_end_y;
            r_ax <= PW'(i_start_x) <<< FRAC_BITS;
            r_ay <= PW'(i_start_y) <<< FRAC_BITS;
            r_bx <= PW'(i_end_x) <<< FRAC_BITS;
            r_by <= PW'(i_end_y) <<< FRAC_BITS;
            r_c0 <= region(in_sx, in_sy, i_win_left, i_win_top, i_win_right, i_win_bottom);
            r_c1 <= region(in_ex, in_ey, i_win_left, i_win_top, i_win_right, i_win_bottom);
        end
        if (i_cmd.setup) begin
            r_side <= (r_c0 == 4'd0);
            r_is_y <= use_y;
            r_edge <= edge_fx;
            r_span <= DW'(q1) - DW'(q0);
            r_base <= q0;
            r_neg  <= num[DW-1] ^ den[DW-1];
            r_zero <= (den == '0);
            r_quo  <= NW'(num[DW-1] ? -num : num) << FRAC_BITS;
            r_den  <= den[DW-1] ? -den : den;
            r_rem  <= '0;
            r_cnt  <= CW'(NW - 1);
        end
        if (i_cmd.div_step) begin
            if (!rem_sub[DW]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.lerp) begin
            // quotient magnitude is truncated toward zero; a negative ratio clamps to 0
            r_prod <= MW'(r_span) * $signed({1'b0, t_val});
        end
        if (i_cmd.update) begin
            if (!r_side) begin
                r_ax <= nx;
                r_ay <= ny;
                r_c0 <= nc;
            end else begin
                r_bx <= nx;
                r_by <= ny;
                r_c1 <= nc;
            end
        end
        if (i_cmd.finish) begin
            r_vis <= ((r_c0 | r_c1) == 4'd0);
            if ((r_c0 | r_c1) == 4'd0) begin
                r_osx <= r_ax[FRAC_BITS+CoordW-1:FRAC_BITS];
                r_osy <= r_ay[FRAC_BITS+CoordW-1:FRAC_BITS];
                r_oex <= r_bx[FRAC_BITS+CoordW-1:FRAC_BITS];
                r_oey <= r_by[FRAC_BITS+CoordW-1:FRAC_BITS];
            end else begin
                r_osx <= r_sx;
                r_osy <= r_sy;
                r_oex <= r_ex;
                r_oey <= r_ey;
            end
        end
    end

    assign o_status.reject   = ((r_c0 & r_c1) != 4'd0);
    assign o_status.accept   = ((r_c0 | r_c1) == 4'd0);
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.zero_den = r_zero;

    assign o_visible      = r_vis;
    assign o_clip_start_x = r_osx;
    assign o_clip_start_y = r_osy;
    assign o_clip_end_x   = r_oex;
    assign o_clip_end_y   = r_oey;

endmodule

FILE: src/lcfp_ctrl.sv
module lcfp_ctrl
    import lcfp_pkg::*;
#(
    parameter int unsigned MAX_PASSES = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_done
);

    localparam int unsigned PCW = $clog2(MAX_PASSES + 1);

    t_state         r_state, n_state;
    logic [PCW-1:0] r_passes, n_passes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_passes <= '0;
        end else begin
            r_state  <= n_state;
            r_passes <= n_passes;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_passes = r_passes;
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_passes   = '0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.reject || i_status.accept
                        || r_passes == PCW'(MAX_PASSES)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_passes    = r_passes + PCW'(1);
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.zero_den) begin
                    // report invisible: force a reject by finishing now
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) n_state = S_LERP;
                end
            end
            S_LERP: begin
                o_cmd.lerp = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
